[design/leb_pkg.sv]
// Shared types and constants for the line edit buffer.
// No dependencies; imported by every other module of the block.
`default_nettype none

package leb_pkg;

	localparam int unsigned LINE_DEPTH_DEF = 32;
	localparam int unsigned CHAR_W         = 8;
	localparam int unsigned CFG_IDX_W      = 3;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ERASE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KILL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLUSH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_END = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEP      = 3'd5;

	// Reset values of the configuration registers
	localparam logic [CHAR_W-1:0] ERASE_RST    = 8'd42;
	localparam logic [CHAR_W-1:0] WORD_RST     = 8'd36;
	localparam logic [CHAR_W-1:0] KILL_RST     = 8'd38;
	localparam logic [CHAR_W-1:0] FLUSH_RST    = 8'd64;
	localparam logic [CHAR_W-1:0] LINE_END_RST = 8'd10;
	localparam logic [CHAR_W-1:0] SEP_RST      = 8'd32;

	// Kind of an incoming beat
	typedef enum logic [2:0] {
		CLS_ERASE,
		CLS_FLUSH,
		CLS_WORD,
		CLS_KILL,
		CLS_APPEND
	} char_cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORD,
		ST_EMIT
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic edit;   // apply the edit for the accepted beat
		logic start;  // clear scan/emit counters
		logic scan;   // word-erase scan in progress
		logic emit;   // line emission in progress
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		char_cls_t cls;
		logic      scan_done;
		logic      emit_done;
	} dp_status_t;

endpackage

`default_nettype wire

[design/line_edit_buffer_unit.sv]
// Top level of the line edit buffer: tty-style canonical line editing.
// Depends on leb_pkg, leb_ctrl and leb_dpath.
//
//  channel  dir  signals                      beat contents (low bit up)
//  s_*      in   tvalid tready tdata tuser    tdata: in_char[7:0]; tuser: end_of_input
//  m_*      out  tvalid tready tdata tlast tuser
//                                              tdata: out_char[7:0]; tlast: last;
//                                              tuser: overflowed
//  cfg_*    in   we index data                index 0..5 = erase, word erase, kill,
//                                              flush, line end, separator
//
// Erase, kill and append are applied when their beat is taken. A word erase
// scans the stored line through the store's single registered read port;
// input is held off until the scan is done.
// A flush streams one character per cycle from the read port while the output
// is not stalled, then the newline.
// Output backpressure stalls the flush; the final beat sits in the output
// register while the next input beat is already taken.
// Reset clears length, overflow flag and control; the line store needs none.
`default_nettype none

module line_edit_buffer_unit
	import leb_pkg::*;
#(
	parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // in_char[7:0]
	input  wire logic                 s_tuser,   // end_of_input
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata,   // out_char[7:0]
	output logic                      m_tlast,
	output logic                      m_tuser,   // overflowed
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	leb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	leb_dpath #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_char      (s_tdata),
		.end_of_input (s_tuser),
		.cmd          (cmd),
		.status       (status),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.out_char     (m_tdata),
		.out_last     (m_tlast),
		.out_ovf      (m_tuser)
	);

	// end of emission returns the controller to idle
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit_done |=> s_tready)
		else $error("controller not idle after newline beat");

	// a flush beat locks the input until the line is out
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && status.cls == CLS_FLUSH) |=> !s_tready)
		else $error("input taken during a flush");

	// the closing beat always carries the newline code
	a_last_nl: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata == NEWLINE_CODE))
		else $error("last beat is not a newline");

	// a scan and an emission never run together
	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan && cmd.emit))
		else $error("scan and emit both active");

endmodule

`default_nettype wire

[design/leb_ctrl.sv]
// Controller state machine of the line edit buffer.
// Depends on leb_pkg; talks to leb_dpath through command and status structs.
`default_nettype none

module leb_ctrl
	import leb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire dp_status_t status,
	output ctl_cmd_t        cmd
);

	ctl_state_t state_q, state_d;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		accept    = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				accept   = s_tvalid;
				if (accept) begin
					unique case (status.cls)
						CLS_WORD: begin
							cmd.start = 1'b1;
							state_d   = ST_WORD;
						end
						CLS_FLUSH: begin
							cmd.start = 1'b1;
							state_d   = ST_EMIT;
						end
						default: begin
							cmd.edit = 1'b1;
						end
					endcase
				end
			end
			ST_WORD: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[design/leb_dpath.sv]
// Datapath of the line edit buffer: config registers, line store memory,
// word-erase scanner and output register. Depends on leb_pkg.
`default_nettype none

module leb_dpath
	import leb_pkg::*;
#(
	parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CHAR_W-1:0]    cfg_data,
	input  wire logic [CHAR_W-1:0]    in_char,
	input  wire logic                 end_of_input,
	input  wire ctl_cmd_t             cmd,
	output dp_status_t                status,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [CHAR_W-1:0]         out_char,
	output logic                      out_last,
	output logic                      out_ovf
);

	localparam int unsigned LEN_W  = $clog2(LINE_DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(LINE_DEPTH);
	localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LINE_DEPTH);

	logic [CHAR_W-1:0] erase_q, word_q, kill_q, flush_q, line_end_q, sep_q;

	logic [CHAR_W-1:0] mem [LINE_DEPTH];
	logic [CHAR_W-1:0] rdata_q;
	logic              pend_q;
	logic [ADDR_W-1:0] pidx_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;

	logic [ADDR_W-1:0] last_sep_q, prev_run_q;
	logic              in_run_q;
	logic [LEN_W-1:0]  cut;

	char_cls_t cls;
	logic      scan_done;

	logic out_valid_q, out_free, more, issue, consume, load_char, load_nl, wr_en;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q    <= ERASE_RST;
			word_q     <= WORD_RST;
			kill_q     <= KILL_RST;
			flush_q    <= FLUSH_RST;
			line_end_q <= LINE_END_RST;
			sep_q      <= SEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ERASE:    erase_q    <= cfg_data;
				REG_WORD:     word_q     <= cfg_data;
				REG_KILL:     kill_q     <= cfg_data;
				REG_FLUSH:    flush_q    <= cfg_data;
				REG_LINE_END: line_end_q <= cfg_data;
				REG_SEP:      sep_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify incoming beat, first match wins
	always_comb begin
		if (end_of_input)
			cls = CLS_FLUSH;
		else if (in_char == erase_q)
			cls = CLS_ERASE;
		else if (in_char == flush_q || in_char == line_end_q)
			cls = CLS_FLUSH;
		else if (in_char == word_q)
			cls = CLS_WORD;
		else if (in_char == kill_q)
			cls = CLS_KILL;
		else
			cls = CLS_APPEND;
	end

	assign out_free  = !out_valid_q || m_tready;
	assign more      = idx_q < len_q;
	assign load_char = cmd.emit && pend_q && out_free;
	assign load_nl   = cmd.emit && !more && !pend_q && out_free;
	assign consume   = (cmd.scan && pend_q) || load_char;
	assign issue     = more && ((cmd.scan) || (cmd.emit && (!pend_q || load_char)));
	assign wr_en     = cmd.edit && cls == CLS_APPEND && len_q < DEPTH_L;
	assign scan_done = cmd.scan && !more && !pend_q;

	assign status = {cls, scan_done, load_nl};

	// cut point from the separator trackers; position 0 counts as none
	always_comb begin
		if (in_run_q)
			cut = (prev_run_q == '0) ? '0 : LEN_W'(prev_run_q) + LEN_W'(1);
		else
			cut = (last_sep_q == '0) ? '0 : LEN_W'(last_sep_q) + LEN_W'(1);
	end

	// line store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[len_q[ADDR_W-1:0]] <= in_char;
		if (issue) begin
			rdata_q <= mem[idx_q[ADDR_W-1:0]];
			pidx_q  <= idx_q[ADDR_W-1:0];
		end
	end

	// word scan trackers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			last_sep_q <= '0;
			prev_run_q <= '0;
			in_run_q   <= 1'b0;
		end else if (cmd.scan && pend_q) begin
			if (rdata_q == sep_q) begin
				if (!in_run_q)
					prev_run_q <= last_sep_q;
				last_sep_q <= pidx_q;
				in_run_q   <= 1'b1;
			end else begin
				in_run_q <= 1'b0;
			end
		end
	end

	// control state: counters, length, overflow, read pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.start)
				idx_q <= '0;
			else if (issue)
				idx_q <= idx_q + LEN_W'(1);

			if (issue)
				pend_q <= 1'b1;
			else if (consume)
				pend_q <= 1'b0;

			if (cmd.edit) begin
				case (cls)
					CLS_ERASE: if (len_q != '0) len_q <= len_q - LEN_W'(1);
					CLS_KILL:  len_q <= '0;
					CLS_APPEND: begin
						if (len_q < DEPTH_L)
							len_q <= len_q + LEN_W'(1);
						else
							ovf_q <= 1'b1;
					end
					default: ;
				endcase
			end else if (scan_done) begin
				len_q <= cut;
			end else if (load_nl) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_char || load_nl) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_char) begin
			out_char <= rdata_q;
			out_last <= 1'b0;
			out_ovf  <= ovf_q;
		end else if (load_nl) begin
			out_char <= NEWLINE_CODE;
			out_last <= 1'b1;
			out_ovf  <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire
